@@ sv/fttc_pkg.sv @@
`default_nettype none

package fttc_pkg;

   localparam logic [2:0] CMD_START_REPLY   = 3'd0;
   localparam logic [2:0] CMD_START_NOREPLY = 3'd1;
   localparam logic [2:0] CMD_TX_READY      = 3'd2;
   localparam logic [2:0] CMD_TX_COMPLETE   = 3'd3;
   localparam logic [2:0] CMD_RX_BYTE       = 3'd4;
   localparam logic [2:0] CMD_RESET         = 3'd5;

   localparam logic [2:0] EV_NONE          = 3'd0;
   localparam logic [2:0] EV_REQ_SENT      = 3'd1;
   localparam logic [2:0] EV_NOREPLY_DONE  = 3'd2;
   localparam logic [2:0] EV_REPLY_DONE    = 3'd3;
   localparam logic [2:0] EV_REPLY_ERROR   = 3'd4;
   localparam logic [2:0] EV_START_REJECT  = 3'd5;

   localparam logic [1:0] PH_IDLE         = 2'd0;
   localparam logic [1:0] PH_SEND_REPLY   = 2'd1;
   localparam logic [1:0] PH_SEND_NOREPLY = 2'd2;
   localparam logic [1:0] PH_RECV         = 2'd3;

   localparam logic [7:0] DEL_SD1 = 8'h10;
   localparam logic [7:0] DEL_SD2 = 8'h68;
   localparam logic [7:0] DEL_SD3 = 8'hA2;
   localparam logic [7:0] DEL_SD4 = 8'hDC;
   localparam logic [7:0] DEL_SC  = 8'hE5;

   localparam logic [7:0] SIZE_SD1       = 8'd6;
   localparam logic [7:0] SIZE_SD2_EXTRA = 8'd6;
   localparam logic [7:0] SIZE_SD3       = 8'd14;
   localparam logic [7:0] SIZE_SD4       = 8'd3;
   localparam logic [7:0] SIZE_SC        = 8'd1;
   localparam logic [7:0] LE_MIN         = 8'd4;
   localparam logic [7:0] LE_MAX         = 8'd249;

   typedef logic [7:0] byte_type;

   // Telegram length in bytes, or zero for an unknown delimiter or a bad LE/LEr pair.
   function automatic byte_type telegram_bytes(input byte_type sd, input byte_type le,
                                               input byte_type ler);
      byte_type n;
      case (sd)
         DEL_SD1: n = SIZE_SD1;
         DEL_SD2: begin
            if (le != ler || le < LE_MIN || le > LE_MAX) n = 8'd0;
            else n = le + SIZE_SD2_EXTRA;
         end
         DEL_SD3: n = SIZE_SD3;
         DEL_SD4: n = SIZE_SD4;
         DEL_SC:  n = SIZE_SC;
         default: n = 8'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

@@ sv/fttc_req_if.sv @@
`default_nettype none

interface fttc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] cmd;
   logic [7:0] req_delim;
   logic [7:0] req_len;
   logic [7:0] req_len_rep;
   logic [7:0] rx_data;

   modport source (output valid, cmd, req_delim, req_len, req_len_rep, rx_data,
                   input ready);
   modport sink (input valid, cmd, req_delim, req_len, req_len_rep, rx_data,
                 output ready);
endinterface

`default_nettype wire

@@ sv/fttc_rsp_if.sv @@
`default_nettype none

interface fttc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_res;
   logic [7:0] event_size;
   logic       tx_valid;
   logic [7:0] tx_index;
   logic       store_valid;
   logic [7:0] store_index;
   logic       line_drive;
   logic       rx_enabled;
   logic       busy_res;

   modport source (output valid, event_res, event_size, tx_valid, tx_index, store_valid,
                   store_index, line_drive, rx_enabled, busy_res,
                   input ready);
   modport sink (input valid, event_res, event_size, tx_valid, tx_index, store_valid,
                 store_index, line_drive, rx_enabled, busy_res,
                 output ready);
endinterface

`default_nettype wire

@@ sv/fieldbus_telegram_transfer_control.sv @@
// Half-duplex fieldbus telegram sequencer.
// Each transfer on the req channel carries one event: a start (with or without reply),
// transmitter ready, transmit complete, a received byte, or a soft reset. For every
// transfer accepted, exactly one result leaves on the rsp channel: the event code, the
// reply size, the request byte index to send, the buffer index for a received byte and
// the line, receiver and busy flags as they stand after the event.
// The state is updated at the edge that accepts the transfer and the result is held in
// an output register, so the result appears in the cycle after acceptance. A new
// transfer is accepted every cycle unless the receiver stalls, one item per cycle
// sustained, set by the single state update. While a result waits, req.ready follows
// rsp.ready; on a stall, one result is held and req.ready falls until it is taken.
// The reset input clears the sequencer to idle and empties the output register; the
// reset command does the same to the sequencer state but still returns a result.
`default_nettype none

module fieldbus_telegram_transfer_control (
   input wire logic  clock,
   input wire logic  reset,
   fttc_req_if.sink   req,
   fttc_rsp_if.source rsp
);
   import fttc_pkg::*;

   logic [1:0] phase_ff, phase_in;
   logic [7:0] frame_size_ff, frame_size_in;
   logic [7:0] byte_pos_ff, byte_pos_in;
   logic       tail_pending_ff, tail_pending_in;
   logic [7:0] reply_delim_ff, reply_delim_in;
   logic [7:0] reply_len_ff, reply_len_in;

   logic       rsp_valid_ff;
   logic [2:0] event_res_ff, event_res_in;
   logic [7:0] event_size_ff, event_size_in;
   logic       tx_valid_ff, tx_valid_in;
   logic [7:0] tx_index_ff, tx_index_in;
   logic       store_valid_ff, store_valid_in;
   logic [7:0] store_index_ff, store_index_in;
   logic       line_drive_ff, rx_enabled_ff, busy_res_ff;

   logic       accept;
   logic       sending;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign sending   = (phase_ff == PH_SEND_REPLY) || (phase_ff == PH_SEND_NOREPLY);

   always_comb begin
      logic [7:0] n;
      logic [7:0] pos;
      logic       done;
      n               = telegram_bytes(req.req_delim, req.req_len, req.req_len_rep);
      pos             = byte_pos_ff + 8'd1;
      done            = 1'b0;
      phase_in        = phase_ff;
      frame_size_in   = frame_size_ff;
      byte_pos_in     = byte_pos_ff;
      tail_pending_in = tail_pending_ff;
      reply_delim_in  = reply_delim_ff;
      reply_len_in    = reply_len_ff;
      event_res_in    = EV_NONE;
      event_size_in   = 8'd0;
      tx_valid_in     = 1'b0;
      tx_index_in     = 8'd0;
      store_valid_in  = 1'b0;
      store_index_in  = 8'd0;
      case (req.cmd)
         CMD_START_REPLY, CMD_START_NOREPLY: begin
            if (n == 8'd0 || phase_ff != PH_IDLE) begin
               event_res_in = EV_START_REJECT;
            end else begin
               phase_in        = (req.cmd == CMD_START_REPLY) ? PH_SEND_REPLY
                                                              : PH_SEND_NOREPLY;
               frame_size_in   = n;
               tail_pending_in = 1'b0;
               tx_valid_in     = 1'b1;
               byte_pos_in     = 8'd1;
            end
         end
         CMD_TX_READY: begin
            if (sending && !tail_pending_ff) begin
               if (byte_pos_ff >= frame_size_ff) begin
                  tail_pending_in = 1'b1;
               end else begin
                  tx_valid_in = 1'b1;
                  tx_index_in = byte_pos_ff;
                  byte_pos_in = pos;
               end
            end
         end
         CMD_TX_COMPLETE: begin
            if (tail_pending_ff) begin
               tail_pending_in = 1'b0;
               if (phase_ff == PH_SEND_REPLY) begin
                  phase_in      = PH_RECV;
                  frame_size_in = 8'd0;
                  byte_pos_in   = 8'd0;
                  event_res_in  = EV_REQ_SENT;
               end else if (phase_ff == PH_SEND_NOREPLY) begin
                  phase_in     = PH_IDLE;
                  event_res_in = EV_NOREPLY_DONE;
               end
            end
         end
         CMD_RX_BYTE: begin
            if (phase_ff == PH_RECV) begin
               store_valid_in = 1'b1;
               store_index_in = byte_pos_ff;
               byte_pos_in    = pos;
               if (pos == 8'd1) begin
                  reply_delim_in = req.rx_data;
                  if (req.rx_data != DEL_SD2) begin
                     frame_size_in = telegram_bytes(req.rx_data, 8'd0, 8'd0);
                     if (frame_size_in == 8'd0) begin
                        event_res_in = EV_REPLY_ERROR;
                        phase_in     = PH_IDLE;
                        done         = 1'b1;
                     end
                  end
               end else if (pos == 8'd2) begin
                  reply_len_in = req.rx_data;
               end
               if (!done && frame_size_in != 8'd0 && pos >= frame_size_in) begin
                  event_res_in  = EV_REPLY_DONE;
                  event_size_in = frame_size_in;
                  phase_in      = PH_IDLE;
                  done          = 1'b1;
               end
               if (!done && frame_size_in == 8'd0 && pos == 8'd3
                   && reply_delim_in == DEL_SD2) begin
                  frame_size_in = telegram_bytes(DEL_SD2, reply_len_in, req.rx_data);
                  if (frame_size_in == 8'd0) begin
                     event_res_in = EV_REPLY_ERROR;
                     phase_in     = PH_IDLE;
                  end
               end
            end
         end
         CMD_RESET: begin
            phase_in        = PH_IDLE;
            frame_size_in   = 8'd0;
            byte_pos_in     = 8'd0;
            tail_pending_in = 1'b0;
            reply_delim_in  = 8'd0;
            reply_len_in    = 8'd0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         frame_size_ff   <= 8'd0;
         byte_pos_ff     <= 8'd0;
         tail_pending_ff <= 1'b0;
         reply_delim_ff  <= 8'd0;
         reply_len_ff    <= 8'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff        <= phase_in;
            frame_size_ff   <= frame_size_in;
            byte_pos_ff     <= byte_pos_in;
            tail_pending_ff <= tail_pending_in;
            reply_delim_ff  <= reply_delim_in;
            reply_len_ff    <= reply_len_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         event_res_ff   <= event_res_in;
         event_size_ff  <= event_size_in;
         tx_valid_ff    <= tx_valid_in;
         tx_index_ff    <= tx_index_in;
         store_valid_ff <= store_valid_in;
         store_index_ff <= store_index_in;
         line_drive_ff  <= (phase_in == PH_SEND_REPLY) || (phase_in == PH_SEND_NOREPLY);
         rx_enabled_ff  <= (phase_in == PH_RECV);
         busy_res_ff    <= (phase_in != PH_IDLE);
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.event_res   = event_res_ff;
   assign rsp.event_size  = event_size_ff;
   assign rsp.tx_valid    = tx_valid_ff;
   assign rsp.tx_index    = tx_index_ff;
   assign rsp.store_valid = store_valid_ff;
   assign rsp.store_index = store_index_ff;
   assign rsp.line_drive  = line_drive_ff;
   assign rsp.rx_enabled  = rx_enabled_ff;
   assign rsp.busy_res    = busy_res_ff;

   a_tail_only_sending: assert property (@(posedge clock) disable iff (reset)
      tail_pending_ff |-> sending)
      else $error("Tail pending outside a sending phase.");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("Result register not empty after reset.");

   a_flags_agree: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.busy_res == (rsp.line_drive || rsp.rx_enabled))
                    && !(rsp.line_drive && rsp.rx_enabled))
      else $error("Line, receiver and busy flags disagree.");

   a_tx_only_when_sending: assert property (@(posedge clock) disable iff (reset)
      accept ##1 (rsp.valid && rsp.tx_valid) |-> rsp.line_drive)
      else $error("Transmit index handed out while the line is not driven.");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fttc_pkg::*;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] req_delim;
      logic [7:0] req_len;
      logic [7:0] req_len_rep;
      logic [7:0] rx_data;
   } bus_event_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] event_size;
      logic       tx_valid;
      logic [7:0] tx_index;
      logic       store_valid;
      logic [7:0] store_index;
      logic       line_drive;
      logic       rx_enabled;
      logic       busy_res;
   } bus_outcome_type;

   class telegram_scoreboard;
      logic [1:0]      phase;
      byte_type        frame_size;
      byte_type        byte_pos;
      logic            tail_pending;
      byte_type        reply_delim;
      byte_type        reply_len;
      bus_outcome_type expected_outcomes[$];
      int              mismatches;

      function new();
         clear_sequencer();
         mismatches = 0;
      endfunction

      function void clear_sequencer();
         phase = PH_IDLE;
         frame_size = 8'd0;
         byte_pos = 8'd0;
         tail_pending = 1'b0;
         reply_delim = 8'd0;
         reply_len = 8'd0;
      endfunction

      // Telegram size from its delimiter and length pair, or zero when it cannot be framed.
      function byte_type frame_bytes(byte_type sd, byte_type le, byte_type ler);
         byte_type n;
         n = 8'd0;
         if (sd == DEL_SD1) n = SIZE_SD1;
         else if (sd == DEL_SD3) n = SIZE_SD3;
         else if (sd == DEL_SD4) n = SIZE_SD4;
         else if (sd == DEL_SC) n = SIZE_SC;
         else if (sd == DEL_SD2 && le == ler && le >= LE_MIN && le <= LE_MAX)
            n = le + SIZE_SD2_EXTRA;
         return n;
      endfunction

      function int outstanding();
         return expected_outcomes.size();
      endfunction

      function bit passed();
         return mismatches == 0 && expected_outcomes.size() == 0;
      endfunction

      function string describe(bus_outcome_type o);
         return $sformatf("ev %0d size %0d tx %0b:%0d store %0b:%0d line %0b rx %0b busy %0b",
                          o.event_res, o.event_size, o.tx_valid, o.tx_index, o.store_valid,
                          o.store_index, o.line_drive, o.rx_enabled, o.busy_res);
      endfunction

      function void note_event(bus_event_type e);
         bus_outcome_type o;
         byte_type        n;
         bit              closed;
         bit              bad;
         o = '0;
         closed = 1'b0;
         bad = 1'b0;
         case (e.cmd)
            CMD_START_REPLY, CMD_START_NOREPLY: begin
               n = frame_bytes(e.req_delim, e.req_len, e.req_len_rep);
               if (n == 8'd0 || phase != PH_IDLE) begin
                  o.event_res = EV_START_REJECT;
               end else begin
                  phase = (e.cmd == CMD_START_REPLY) ? PH_SEND_REPLY : PH_SEND_NOREPLY;
                  frame_size = n;
                  tail_pending = 1'b0;
                  o.tx_valid = 1'b1;
                  o.tx_index = 8'd0;
                  byte_pos = 8'd1;
               end
            end
            CMD_TX_READY: begin
               if ((phase == PH_SEND_REPLY || phase == PH_SEND_NOREPLY) && !tail_pending) begin
                  if (byte_pos >= frame_size) begin
                     tail_pending = 1'b1;
                  end else begin
                     o.tx_valid = 1'b1;
                     o.tx_index = byte_pos;
                     byte_pos = byte_pos + 8'd1;
                  end
               end
            end
            CMD_TX_COMPLETE: begin
               if (tail_pending) begin
                  tail_pending = 1'b0;
                  if (phase == PH_SEND_REPLY) begin
                     phase = PH_RECV;
                     frame_size = 8'd0;
                     byte_pos = 8'd0;
                     o.event_res = EV_REQ_SENT;
                  end else if (phase == PH_SEND_NOREPLY) begin
                     phase = PH_IDLE;
                     o.event_res = EV_NOREPLY_DONE;
                  end
               end
            end
            CMD_RX_BYTE: begin
               if (phase == PH_RECV) begin
                  o.store_valid = 1'b1;
                  o.store_index = byte_pos;
                  byte_pos = byte_pos + 8'd1;
                  if (byte_pos == 8'd1) begin
                     reply_delim = e.rx_data;
                     if (e.rx_data != DEL_SD2) begin
                        frame_size = frame_bytes(e.rx_data, 8'd0, 8'd0);
                        closed = frame_size == 8'd0;
                        bad = closed;
                     end
                  end else if (byte_pos == 8'd2) begin
                     reply_len = e.rx_data;
                  end
                  if (!closed) begin
                     if (frame_size != 8'd0 && byte_pos >= frame_size) begin
                        closed = 1'b1;
                     end else if (frame_size == 8'd0 && byte_pos == 8'd3 &&
                                  reply_delim == DEL_SD2) begin
                        frame_size = frame_bytes(DEL_SD2, reply_len, e.rx_data);
                        closed = frame_size == 8'd0;
                        bad = closed;
                     end
                  end
                  if (closed) begin
                     o.event_res = bad ? EV_REPLY_ERROR : EV_REPLY_DONE;
                     o.event_size = frame_size;
                     phase = PH_IDLE;
                  end
               end
            end
            CMD_RESET: begin
               clear_sequencer();
            end
            default: begin
            end
         endcase
         o.line_drive = phase == PH_SEND_REPLY || phase == PH_SEND_NOREPLY;
         o.rx_enabled = phase == PH_RECV;
         o.busy_res = phase != PH_IDLE;
         expected_outcomes.push_back(o);
      endfunction

      function void check_outcome(bus_outcome_type got);
         bus_outcome_type want;
         if (expected_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with nothing outstanding: %s", $time, describe(got));
            return;
         end
         want = expected_outcomes.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: result mismatch", $time);
               $display("   expected %s", describe(want));
               $display("   actual   %s", describe(got));
            end
         end
      endfunction
   endclass

   localparam logic [2:0] CMD_SPARE_LO = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   localparam int         ITEM_TARGET = 1400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   steady = 1'b0;
   int   sent_count = 0;

   telegram_scoreboard sb = new();

   fttc_req_if req_bus ();
   fttc_rsp_if rsp_bus ();

   fieldbus_telegram_transfer_control dut (
      .clock(clock),
      .reset(reset),
      .req  (req_bus),
      .rsp  (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_event({req_bus.cmd, req_bus.req_delim, req_bus.req_len,
                           req_bus.req_len_rep, req_bus.rx_data});
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_outcome({rsp_bus.event_res, rsp_bus.event_size, rsp_bus.tx_valid,
                              rsp_bus.tx_index, rsp_bus.store_valid, rsp_bus.store_index,
                              rsp_bus.line_drive, rsp_bus.rx_enabled, rsp_bus.busy_res});
      end
   end

   initial begin
      #10_000_000;
      $display("tb NOT OK");
      $finish;
   end

   // Mostly short gaps, a few long ones, and none at all during a steady stretch.
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic byte_type any_byte();
      return byte_type'($urandom_range(0, 255));
   endfunction

   function automatic byte_type pick_delim();
      case ($urandom_range(0, 4))
         0: return DEL_SD1;
         1: return DEL_SD2;
         2: return DEL_SD3;
         3: return DEL_SD4;
         default: return DEL_SC;
      endcase
   endfunction

   function automatic byte_type pick_le();
      if ($urandom_range(0, 99) < 92) return byte_type'($urandom_range(LE_MIN, 12));
      return byte_type'($urandom_range(13, LE_MAX));
   endfunction

   initial begin
      int span;
      rsp_bus.ready = 1'b0;
      forever begin
         span = idle_span();
         @(negedge clock);
         if (span > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (span) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
   end

   task automatic send_event(input logic [2:0] cmd, input byte_type delim, input byte_type le,
                             input byte_type ler, input byte_type data);
      int gap;
      gap = idle_span();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= cmd;
      req_bus.req_delim <= delim;
      req_bus.req_len <= le;
      req_bus.req_len_rep <= ler;
      req_bus.rx_data <= data;
      do @(posedge clock); while (!req_bus.ready);
      sent_count++;
   endtask

   task automatic send_cmd(input logic [2:0] cmd);
      send_event(cmd, any_byte(), any_byte(), any_byte(), any_byte());
   endtask

   task automatic send_rx(input byte_type data);
      send_event(CMD_RX_BYTE, any_byte(), any_byte(), any_byte(), data);
   endtask

   task automatic send_noise();
      logic [2:0] cmd;
      byte_type   le;
      cmd = $urandom_range(0, 1) ? CMD_START_REPLY : CMD_START_NOREPLY;
      le = any_byte();
      case ($urandom_range(0, 3))
         0: send_event(cmd, DEL_SD2, le, $urandom_range(0, 1) ? le : any_byte(), any_byte());
         1: send_event(cmd, pick_delim(), le, le, any_byte());
         default: send_cmd(3'($urandom_range(0, 7)));
      endcase
   endtask

   // The transfer queue empties before the sender carries on.
   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   task automatic send_reply(input bit big);
      byte_type body[$];
      byte_type sd;
      byte_type le;
      byte_type ler;
      int       kind;
      int       cut;
      kind = big ? 6 : $urandom_range(0, 9);
      if (kind < 6) begin
         case (kind % 4)
            0: sd = DEL_SD1;
            1: sd = DEL_SD3;
            2: sd = DEL_SD4;
            default: sd = DEL_SC;
         endcase
         body.push_back(sd);
         repeat (sb.frame_bytes(sd, 8'd0, 8'd0) - 1) body.push_back(any_byte());
      end else if (kind < 8) begin
         le = big ? LE_MAX : pick_le();
         body.push_back(DEL_SD2);
         body.push_back(le);
         body.push_back(le);
         repeat (le + 3) body.push_back(any_byte());
      end else if (kind == 8) begin
         do sd = any_byte(); while (sd == DEL_SD2 || sb.frame_bytes(sd, 8'd0, 8'd0) != 8'd0);
         body.push_back(sd);
      end else begin
         le = any_byte();
         ler = $urandom_range(0, 1) ? le : any_byte();
         if (sb.frame_bytes(DEL_SD2, le, ler) != 8'd0) ler = le + 8'd1;
         body.push_back(DEL_SD2);
         body.push_back(le);
         body.push_back(ler);
      end
      cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, body.size() - 1) : -1;
      foreach (body[i]) begin
         if (i == cut) begin
            send_cmd(CMD_RESET);
            return;
         end
         send_rx(body[i]);
      end
      if ($urandom_range(0, 4) == 0) send_rx(any_byte());
   endtask

   task automatic run_exchange(input bit big);
      logic [2:0] start_cmd;
      byte_type   sd;
      byte_type   le;
      int         nbytes;
      int         cut;
      start_cmd = (big || $urandom_range(0, 1)) ? CMD_START_REPLY : CMD_START_NOREPLY;
      sd = big ? DEL_SD2 : pick_delim();
      le = big ? LE_MAX : pick_le();
      nbytes = sb.frame_bytes(sd, le, le);
      // Now and then the exchange is abandoned by the reset command part way through.
      cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, nbytes) : -1;
      send_event(start_cmd, sd, le, le, any_byte());
      for (int i = 0; i < nbytes; i++) begin
         if (i == cut) begin
            send_cmd(CMD_RESET);
            return;
         end
         if ($urandom_range(0, 39) == 0) send_noise();
         send_cmd(CMD_TX_READY);
      end
      if ($urandom_range(0, 3) == 0) send_cmd(CMD_TX_READY);
      send_cmd(CMD_TX_COMPLETE);
      if (start_cmd == CMD_START_REPLY) send_reply(big);
   endtask

   initial begin
      int r;
      bit drained;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_RESET;
      req_bus.req_delim = 8'd0;
      req_bus.req_len = 8'd0;
      req_bus.req_len_rep = 8'd0;
      req_bus.rx_data = 8'd0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_cmd(CMD_TX_READY);
      send_cmd(CMD_TX_COMPLETE);
      send_rx(8'hFF);
      send_cmd(CMD_SPARE_LO);
      send_cmd(CMD_SPARE_HI);
      send_event(CMD_START_REPLY, 8'h00, 8'h00, 8'h00, 8'h00);
      send_event(CMD_START_NOREPLY, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_event(CMD_START_REPLY, DEL_SD2, 8'd8, 8'd9, 8'h00);
      send_event(CMD_START_REPLY, DEL_SD2, LE_MIN - 8'd1, LE_MIN - 8'd1, 8'h00);
      send_event(CMD_START_NOREPLY, DEL_SD2, LE_MAX + 8'd1, LE_MAX + 8'd1, 8'h00);
      send_event(CMD_START_NOREPLY, DEL_SC, 8'h00, 8'hFF, 8'h00);
      send_event(CMD_START_REPLY, DEL_SD1, 8'hFF, 8'h00, 8'hFF);
      send_cmd(CMD_TX_COMPLETE);
      send_cmd(CMD_TX_READY);
      send_cmd(CMD_TX_READY);
      send_cmd(CMD_TX_COMPLETE);
      send_event(CMD_START_REPLY, DEL_SD4, 8'h00, 8'h00, 8'h00);
      repeat (3) send_cmd(CMD_TX_READY);
      send_cmd(CMD_TX_COMPLETE);
      send_rx(DEL_SC);
      send_cmd(CMD_RESET);

      run_exchange(1'b1);
      drained = 1'b0;
      while (sent_count < ITEM_TARGET) begin
         steady = sent_count >= 700 && sent_count < 850;
         if (!drained && sent_count >= 500) begin
            drain_results();
            drained = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 75) begin
            run_exchange(1'b0);
         end else if (r < 80) begin
            send_cmd(CMD_RESET);
         end else begin
            repeat ($urandom_range(1, 3)) send_noise();
            if ($urandom_range(0, 2) != 0) send_cmd(CMD_RESET);
         end
      end
      steady = 1'b0;
      drain_results();
      repeat (10) @(negedge clock);
      if (sb.passed()) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule
